@@ hdl/proxy_header_parser_core_assert.svh @@
// Assertion macros used by the port checker file.
`ifndef PROXY_HEADER_PARSER_CORE_ASSERT_SVH
`define PROXY_HEADER_PARSER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PHP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PHP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

@@ hdl/php_pkg.sv @@
// ----------------------------------------------------------------------------
// PROXY header parser package
// Shared types and constants for the parser core and its byte engine.
// ----------------------------------------------------------------------------
package php_pkg;

  localparam int unsigned MaxTextLine = 108;
  localparam logic [16:0] PosMax      = 17'h1FFFF;

  // Parse modes.
  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_V2SIG  = 3'd1,
    MODE_V1SIG  = 3'd2,
    MODE_V2BODY = 3'd3,
    MODE_V1LINE = 3'd4,
    MODE_NONE   = 3'd5,
    MODE_LONG   = 3'd6
  } mode_t;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NONE       = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;
  localparam logic [1:0] ST_BAD_VER    = 2'd3;

  // Configuration register indexes.
  localparam logic [0:0] REG_CMD = 1'd0;
  localparam logic [0:0] REG_FAM = 1'd1;

  // One result item.
  typedef struct packed {
    logic [16:0] consumed_bytes;
    logic [15:0] destination_port;
    logic [15:0] source_port;
    logic [31:0] destination_address;
    logic [31:0] source_address;
    logic        addr_found;
    logic [1:0]  header_version;
    logic [1:0]  status;
  } result_t;

  // Binary signature byte by position.
  function automatic logic [7:0] bin_sig(input logic [3:0] idx);
    logic [7:0] v;
    unique case (idx)
      4'd0, 4'd2, 4'd5: v = 8'h0D;
      4'd1, 4'd3, 4'd6, 4'd11: v = 8'h0A;
      4'd4: v = 8'h00;
      4'd7: v = 8'h51;
      4'd8: v = 8'h55;
      4'd9: v = 8'h49;
      4'd10: v = 8'h54;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Text prefix byte by position.
  function automatic logic [7:0] text_prefix(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0: v = "P";
      3'd1: v = "R";
      3'd2: v = "O";
      3'd3: v = "X";
      3'd4: v = "Y";
      default: v = " ";
    endcase
    return v;
  endfunction

  function automatic logic [7:0] tcp4_char(input logic [1:0] idx);
    logic [7:0] v;
    unique case (idx)
      2'd0: v = "T";
      2'd1: v = "C";
      2'd2: v = "P";
      default: v = "4";
    endcase
    return v;
  endfunction

endpackage

@@ hdl/php_engine.sv @@
// ----------------------------------------------------------------------------
// PROXY header byte engine
// Holds the parse state and advances it by one buffer byte per transaction.
// Produces the result item when the marked last byte arrives.
// ----------------------------------------------------------------------------
module php_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              end_of_buffer,
  input  logic [7:0]        reg_cmd,
  input  logic [7:0]        reg_fam,
  output php_pkg::result_t  result
);

  localparam logic [16:0] LastLinePos = 17'(php_pkg::MaxTextLine - 1);

  php_pkg::mode_t mode_r, mode_nxt;
  logic [16:0] pos_r, pos_nxt;
  logic        given_r, given_nxt;
  logic [7:0]  cmd_r, cmd_nxt, fam_r, fam_nxt;
  logic [15:0] blen_r, blen_nxt;
  logic [2:0]  tok_r, tok_nxt;
  logic [6:0]  tcc_r, tcc_nxt;
  logic [16:0] acc_r, acc_nxt;
  logic [1:0]  oct_r, oct_nxt;
  logic [2:0]  odig_r, odig_nxt;
  logic        ferr_r, ferr_nxt;
  logic        pcr_r, pcr_nxt;
  logic [31:0] col_r [4];
  logic [31:0] col_nxt [4];
  logic        lhas_r, lhas_nxt;
  logic [16:0] lcons_r, lcons_nxt;

  // Line character handling: optional CR replay, then current byte.
  logic        lc_en [2];
  logic [7:0]  lc_ch [2];

  always_comb begin
    logic [7:0]  b;
    logic [16:0] p;
    logic        done;
    logic [2:0]  tk;
    logic [1:0]  ci;
    logic        dig;
    logic [16:0] acc10;
    logic [1:0]  k;
    b = data_byte;
    p = pos_r;
    tk = '0; ci = '0; dig = 1'b0; acc10 = '0; k = '0;
    mode_nxt = mode_r; given_nxt = given_r; cmd_nxt = cmd_r; fam_nxt = fam_r;
    blen_nxt = blen_r; tok_nxt = tok_r; tcc_nxt = tcc_r; acc_nxt = acc_r;
    oct_nxt = oct_r; odig_nxt = odig_r; ferr_nxt = ferr_r; pcr_nxt = pcr_r;
    for (int i = 0; i < 4; i++) col_nxt[i] = col_r[i];
    lhas_nxt = lhas_r; lcons_nxt = lcons_r;
    done = 1'b0;
    lc_en[0] = 1'b0; lc_en[1] = 1'b0; lc_ch[0] = 8'h0D; lc_ch[1] = b;

    if (!given_r) begin
      unique case (mode_r)
        php_pkg::MODE_START: begin
          mode_nxt = (b == 8'h0D) ? php_pkg::MODE_V2SIG :
                     (b == "P") ? php_pkg::MODE_V1SIG : php_pkg::MODE_NONE;
        end
        php_pkg::MODE_V2SIG: begin
          if (p >= 17'd12 || b != php_pkg::bin_sig(p[3:0])) mode_nxt = php_pkg::MODE_NONE;
          else if (p == 17'd11) mode_nxt = php_pkg::MODE_V2BODY;
        end
        php_pkg::MODE_V1SIG: begin
          if (p >= 17'd6 || b != php_pkg::text_prefix(p[2:0])) mode_nxt = php_pkg::MODE_NONE;
          else if (p == 17'd5) begin
            mode_nxt = php_pkg::MODE_V1LINE;
            tok_nxt = 3'd1;
          end
        end
        php_pkg::MODE_V2BODY: begin
          if (p == 17'd12) cmd_nxt = b;
          else if (p == 17'd13) fam_nxt = b;
          else if (p == 17'd14) blen_nxt = {b, 8'h00};
          else if (p == 17'd15) blen_nxt = {blen_r[15:8], b};
          else if (p <= 17'd27) begin
            k = (p <= 17'd19) ? 2'd0 : (p <= 17'd23) ? 2'd1 : (p <= 17'd25) ? 2'd2 : 2'd3;
            col_nxt[k] = {col_r[k][23:0], b};
          end
          if (p >= 17'd15 && ({1'b0, p} + 18'd1) == (18'd16 + {2'b0, blen_nxt}))
            given_nxt = 1'b1;
        end
        php_pkg::MODE_V1LINE: begin
          if (pcr_r) begin
            pcr_nxt = 1'b0;
            if (b == 8'h0A && p <= LastLinePos) begin
              done = 1'b1;
              given_nxt = 1'b1;
              lcons_nxt = p + 17'd1;
            end else begin
              lc_en[0] = 1'b1;
            end
          end
          if (!done) begin
            if (p >= LastLinePos) mode_nxt = php_pkg::MODE_LONG;
            else if (b == 8'h0D) pcr_nxt = 1'b1;
            else lc_en[1] = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Up to two token characters, in order.
    for (int j = 0; j < 2; j++) begin
      if (lc_en[j]) begin
        if (lc_ch[j] == " ") begin
          if (tcc_nxt != 7'd0) begin
            tk = tok_nxt - 3'd1;
            ci = tk[1:0] - 2'd2;
            if (!ferr_nxt && tk >= 3'd1 && tk <= 3'd5) begin
              if (tk == 3'd1) begin
                if (tcc_nxt != 7'd4) ferr_nxt = 1'b1;
              end else if (tk <= 3'd3) begin
                if (odig_nxt == 3'd0 || oct_nxt != 2'd3) ferr_nxt = 1'b1;
                else col_nxt[ci] = {col_nxt[ci][23:0], acc_nxt[7:0]};
              end else begin
                if (acc_nxt[16]) ferr_nxt = 1'b1;
                else col_nxt[ci] = {16'h0, acc_nxt[15:0]};
              end
            end
            tcc_nxt = 7'd0;
          end
        end else begin
          if (tcc_nxt == 7'd0) begin
            if (tok_nxt < 3'd7) tok_nxt = tok_nxt + 3'd1;
            acc_nxt = '0; oct_nxt = '0; odig_nxt = '0;
          end
          tk = tok_nxt - 3'd1;
          ci = tk[1:0] - 2'd2;
          dig = lc_ch[j] >= "0" && lc_ch[j] <= "9";
          acc10 = 17'({acc_nxt, 3'b0} + {acc_nxt, 1'b0}) + 17'(lc_ch[j] - "0");
          if (!ferr_nxt && tk != 3'd0 && tk <= 3'd5) begin
            if (tk == 3'd1) begin
              if (tcc_nxt >= 7'd4 || lc_ch[j] != php_pkg::tcp4_char(tcc_nxt[1:0]))
                ferr_nxt = 1'b1;
            end else if (tk <= 3'd3) begin
              if (dig) begin
                odig_nxt = odig_nxt + 3'd1;
                acc_nxt = acc10;
                if (odig_nxt > 3'd3 || acc10 > 17'd255) ferr_nxt = 1'b1;
              end else if (lc_ch[j] == ".") begin
                if (odig_nxt == 3'd0 || oct_nxt == 2'd3) ferr_nxt = 1'b1;
                else begin
                  col_nxt[ci] = {col_nxt[ci][23:0], acc_nxt[7:0]};
                  oct_nxt = oct_nxt + 2'd1;
                  odig_nxt = 3'd0;
                  acc_nxt = '0;
                end
              end else ferr_nxt = 1'b1;
            end else begin
              if (!dig || tcc_nxt >= 7'd5) ferr_nxt = 1'b1;
              else acc_nxt = acc10;
            end
          end
          if (tcc_nxt < 7'd127) tcc_nxt = tcc_nxt + 7'd1;
        end
      end
    end

    // Close a pending token at end of line.
    if (done) begin
      if (tcc_nxt != 7'd0) begin
        tk = tok_nxt - 3'd1;
        ci = tk[1:0] - 2'd2;
        if (!ferr_nxt && tk >= 3'd1 && tk <= 3'd5) begin
          if (tk == 3'd1) begin
            if (tcc_nxt != 7'd4) ferr_nxt = 1'b1;
          end else if (tk <= 3'd3) begin
            if (odig_nxt == 3'd0 || oct_nxt != 2'd3) ferr_nxt = 1'b1;
            else col_nxt[ci] = {col_nxt[ci][23:0], acc_nxt[7:0]};
          end else begin
            if (acc_nxt[16]) ferr_nxt = 1'b1;
            else col_nxt[ci] = {16'h0, acc_nxt[15:0]};
          end
        end
        tcc_nxt = 7'd0;
      end
      lhas_nxt = (tok_nxt >= 3'd6) && !ferr_nxt;
    end

    pos_nxt = (pos_r < php_pkg::PosMax) ? pos_r + 17'd1 : pos_r;
  end

  // Result from the updated state.
  always_comb begin
    logic has;
    result = '0;
    result.status = php_pkg::ST_NONE;
    has = 1'b0;
    if (mode_nxt == php_pkg::MODE_V2BODY) begin
      if (!given_nxt) result.status = php_pkg::ST_INCOMPLETE;
      else if (cmd_nxt[7:4] != 4'h2) result.status = php_pkg::ST_BAD_VER;
      else begin
        result.status = php_pkg::ST_OK;
        result.header_version = 2'd2;
        result.consumed_bytes = 17'd16 + {1'b0, blen_nxt};
        has = cmd_nxt == reg_cmd && fam_nxt == reg_fam && blen_nxt >= 16'd12;
      end
    end else if (mode_nxt == php_pkg::MODE_V1LINE || mode_nxt == php_pkg::MODE_LONG) begin
      if (given_nxt) begin
        result.status = php_pkg::ST_OK;
        result.header_version = 2'd1;
        result.consumed_bytes = lcons_nxt;
        has = lhas_nxt;
      end else result.status = php_pkg::ST_INCOMPLETE;
    end
    result.addr_found = has;
    if (has) begin
      result.source_address = col_nxt[0];
      result.destination_address = col_nxt[1];
      result.source_port = col_nxt[2][15:0];
      result.destination_port = col_nxt[3][15:0];
    end
  end

  // State update; the marked byte rearms everything.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && end_of_buffer)) begin
      mode_r <= php_pkg::MODE_START; pos_r <= '0; given_r <= 1'b0; cmd_r <= '0;
      fam_r <= '0; blen_r <= '0; tok_r <= '0; tcc_r <= '0; acc_r <= '0; oct_r <= '0;
      odig_r <= '0; ferr_r <= 1'b0; pcr_r <= 1'b0; lhas_r <= 1'b0; lcons_r <= '0;
      for (int i = 0; i < 4; i++) col_r[i] <= '0;
    end else if (step) begin
      mode_r <= mode_nxt; pos_r <= pos_nxt; given_r <= given_nxt; cmd_r <= cmd_nxt;
      fam_r <= fam_nxt; blen_r <= blen_nxt; tok_r <= tok_nxt; tcc_r <= tcc_nxt;
      acc_r <= acc_nxt; oct_r <= oct_nxt; odig_r <= odig_nxt; ferr_r <= ferr_nxt;
      pcr_r <= pcr_nxt; lhas_r <= lhas_nxt; lcons_r <= lcons_nxt;
      for (int i = 0; i < 4; i++) col_r[i] <= col_nxt[i];
    end
  end

endmodule

@@ hdl/proxy_header_parser_core.sv @@
// A marked byte moves from the input register via the byte engine to the result
// register. Throughput: one byte per cycle; the input register and byte engine
// are refilled in every cycle while the output register can advance.
// Reset: synchronous active-low rst_n clears the parse state, both stages and
// restores the registers to 0x21 and 0x11.
// ----------------------------------------------------------------------------
// PROXY header parser core
// Stream wrapper: input register, byte engine, result register, config port.
// ----------------------------------------------------------------------------
module proxy_header_parser_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // end_of_buffer
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] status, [3:2] header_version, [4] addr_found, [36:5] source_address,
  // [68:37] destination_address, [84:69] source_port, [100:85] destination_port,
  // [117:101] consumed_bytes, [119:118] zero
  output logic [119:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data
);

  logic [7:0] cmd_r, fam_r;
  logic       iv_r;
  logic [7:0] ib_r;
  logic       il_r;
  logic       ov_r;
  php_pkg::result_t res, ores_r;
  logic       adv;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= 8'h21;
      fam_r <= 8'h11;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        php_pkg::REG_CMD: cmd_r <= cfg_data;
        php_pkg::REG_FAM: fam_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage advances on an unmarked byte, or when the result register can take a result.
  assign adv = iv_r && (!(il_r) || !ov_r || out_tready);
  assign in_tready = !iv_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) iv_r <= 1'b0;
    else if (in_tready) iv_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (in_tready) begin
      ib_r <= in_tdata;
      il_r <= in_tlast;
    end
  end

  php_engine u_engine (
    .clk(clk), .rst_n(rst_n), .step(adv), .data_byte(ib_r), .end_of_buffer(il_r),
    .reg_cmd(cmd_r), .reg_fam(fam_r), .result(res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv && il_r) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (adv && il_r) ores_r <= res;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {2'b00, ores_r};

endmodule

@@ hdl/php_checker.sv @@
// ----------------------------------------------------------------------------
// PROXY header parser port checker
// Watches the top-level ports for result consistency and handshake holding.
// ----------------------------------------------------------------------------
`include "proxy_header_parser_core_assert.svh"
module php_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata
);
  `PHP_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `PHP_ASSERT_IMP(a_ver, clk, rst_n, out_tvalid && out_tdata[1:0] != 2'd0, out_tdata[3:2] == 2'd0 && out_tdata[117:101] == 17'd0, "failed status with version or length")
  `PHP_ASSERT_IMP(a_addr, clk, rst_n, out_tvalid && !out_tdata[4], out_tdata[100:5] == 96'd0, "address without addr_found")
  `PHP_ASSERT_IMP(a_has, clk, rst_n, out_tvalid && out_tdata[4], out_tdata[1:0] == 2'd0, "addr_found without parsed header")
endmodule

bind proxy_header_parser_core php_checker u_php_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);

@@ tb/proxy_header_parser_core_checker.sv @@
// ----------------------------------------------------------------------------
// PROXY header parser checker
// Watches the byte, result and register channels of the parser core. It keeps
// its own model of the byte parser, predicts one result per buffer and
// compares every field of each result with the oldest prediction.
// ----------------------------------------------------------------------------
module proxy_header_parser_core_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // end_of_buffer
  input  logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] status, [3:2] header_version, [4] addr_found, [36:5] source_address,
  // [68:37] destination_address, [84:69] source_port, [100:85] destination_port,
  // [117:101] consumed_bytes, [119:118] zero
  input  logic [119:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [7:0]   cfg_data,
  output int           fail_count,
  output int           pending
);

  localparam logic [95:0] BinarySignature = 96'h0D0A0D0A000D0A515549540A;
  localparam logic [47:0] TextPrefix      = "PROXY ";
  localparam logic [31:0] Tcp4Word        = "TCP4";
  localparam logic [7:0]  ChCr            = 8'h0D;
  localparam logic [7:0]  ChLf            = 8'h0A;
  localparam logic [7:0]  ChSpace         = 8'h20;
  localparam logic [7:0]  ChDot           = 8'h2E;

  // Register copies.
  logic [7:0]  proxy_cmd_reg;
  logic [7:0]  tcp4_fam_reg;

  // Parser state.
  logic [16:0]     position;
  php_pkg::mode_t  mode;
  logic            header_done;
  logic [7:0]      hdr_cmd;
  logic [7:0]      hdr_fam;
  logic [15:0]     hdr_len;
  int unsigned     tokens_begun;
  int unsigned     token_len;
  int unsigned     number;
  int unsigned     dots_seen;
  int unsigned     digits;
  logic            bad_field;
  logic            cr_pending;
  logic [31:0]     collect [4];
  logic            text_has_addr;
  logic [16:0]     text_length;

  php_pkg::result_t expected_results [$];
  int               mismatches;

  assign fail_count = mismatches;

  function automatic void clear_parser();
    position      = '0;
    mode          = php_pkg::MODE_START;
    header_done   = 1'b0;
    hdr_cmd       = '0;
    hdr_fam       = '0;
    hdr_len       = '0;
    tokens_begun  = 0;
    token_len     = 0;
    number        = 0;
    dots_seen     = 0;
    digits        = 0;
    bad_field     = 1'b0;
    cr_pending    = 1'b0;
    for (int k = 0; k < 4; k++) collect[k] = '0;
    text_has_addr = 1'b0;
    text_length   = '0;
  endfunction

  // One character of the current token; tok counts tokens from zero.
  function automatic void token_char(int unsigned tok, logic [7:0] c, int unsigned pos_in);
    logic digit;
    digit = (c >= "0") && (c <= "9");
    if (bad_field || tok == 0 || tok > 5) return;
    if (tok == 1) begin
      if (pos_in >= 4) bad_field = 1'b1;
      else if (c != Tcp4Word[31 - 8 * pos_in -: 8]) bad_field = 1'b1;
    end else if (tok <= 3) begin
      if (digit) begin
        digits++;
        number = number * 10 + (c - "0");
        if (digits > 3 || number > 255) bad_field = 1'b1;
      end else if (c == ChDot) begin
        if (digits == 0 || dots_seen >= 3) begin
          bad_field = 1'b1;
        end else begin
          collect[tok - 2] = (collect[tok - 2] << 8) | number[7:0];
          dots_seen++;
          digits = 0;
          number = 0;
        end
      end else begin
        bad_field = 1'b1;
      end
    end else begin
      if (!digit || pos_in >= 5) bad_field = 1'b1;
      else number = number * 10 + (c - "0");
    end
  endfunction

  function automatic void token_end();
    int unsigned tok;
    tok = tokens_begun - 1;
    if (!bad_field && tok >= 1 && tok <= 5) begin
      if (tok == 1) begin
        if (token_len != 4) bad_field = 1'b1;
      end else if (tok <= 3) begin
        if (digits == 0 || dots_seen != 3) bad_field = 1'b1;
        else collect[tok - 2] = (collect[tok - 2] << 8) | number[7:0];
      end else begin
        if (number > 32'hFFFF) bad_field = 1'b1;
        else collect[tok - 2] = number;
      end
    end
    token_len = 0;
  endfunction

  function automatic void line_char(logic [7:0] c);
    if (c == ChSpace) begin
      if (token_len > 0) token_end();
      return;
    end
    if (token_len == 0) begin
      if (tokens_begun < 7) tokens_begun++;
      number    = 0;
      dots_seen = 0;
      digits    = 0;
    end
    token_char(tokens_begun - 1, c, token_len);
    if (token_len < 127) token_len++;
  endfunction

  function automatic void text_line_byte(logic [7:0] b, int unsigned p);
    if (cr_pending) begin
      cr_pending = 1'b0;
      if (b == ChLf && p <= php_pkg::MaxTextLine - 1) begin
        if (token_len > 0) token_end();
        text_has_addr = (tokens_begun >= 6) && !bad_field;
        text_length   = p + 1;
        header_done   = 1'b1;
        return;
      end
      line_char(ChCr);
    end
    if (p >= php_pkg::MaxTextLine - 1) begin
      mode = php_pkg::MODE_LONG;
      return;
    end
    if (b == ChCr) cr_pending = 1'b1;
    else line_char(b);
  endfunction

  function automatic void binary_body_byte(logic [7:0] b, int unsigned p);
    int unsigned k;
    if (p == 12) hdr_cmd = b;
    else if (p == 13) hdr_fam = b;
    else if (p == 14) hdr_len = {b, 8'h00};
    else if (p == 15) hdr_len[7:0] = b;
    else if (p <= 27) begin
      k = (p <= 19) ? 0 : (p <= 23) ? 1 : (p <= 25) ? 2 : 3;
      collect[k] = (collect[k] << 8) | b;
    end
    if (p >= 15 && p + 1 == 16 + int'(hdr_len)) header_done = 1'b1;
  endfunction

  // Advances the model by one accepted byte and queues a result on a marked one.
  function automatic void parse_byte(logic [7:0] b, logic last);
    int unsigned p;
    php_pkg::result_t r;
    p = position;
    if (!header_done) begin
      case (mode)
        php_pkg::MODE_START:
          mode = (b == ChCr) ? php_pkg::MODE_V2SIG :
                 (b == "P") ? php_pkg::MODE_V1SIG : php_pkg::MODE_NONE;
        php_pkg::MODE_V2SIG: begin
          if (p >= 12) mode = php_pkg::MODE_NONE;
          else if (b != BinarySignature[95 - 8 * p -: 8]) mode = php_pkg::MODE_NONE;
          else if (p == 11) mode = php_pkg::MODE_V2BODY;
        end
        php_pkg::MODE_V1SIG: begin
          if (p >= 6) mode = php_pkg::MODE_NONE;
          else if (b != TextPrefix[47 - 8 * p -: 8]) mode = php_pkg::MODE_NONE;
          else if (p == 5) begin
            mode = php_pkg::MODE_V1LINE;
            tokens_begun = 1;
          end
        end
        php_pkg::MODE_V2BODY: binary_body_byte(b, p);
        php_pkg::MODE_V1LINE: text_line_byte(b, p);
        default: ;
      endcase
    end
    if (position != php_pkg::PosMax) position++;
    if (!last) return;

    r = '0;
    r.status = php_pkg::ST_NONE;
    if (mode == php_pkg::MODE_V2BODY) begin
      if (!header_done) begin
        r.status = php_pkg::ST_INCOMPLETE;
      end else if (hdr_cmd[7:4] != 4'h2) begin
        r.status = php_pkg::ST_BAD_VER;
      end else begin
        r.status         = php_pkg::ST_OK;
        r.header_version = 2'd2;
        r.consumed_bytes = 17'd16 + hdr_len;
        r.addr_found     = (hdr_cmd == proxy_cmd_reg) && (hdr_fam == tcp4_fam_reg) &&
                           (hdr_len >= 12);
      end
    end else if (mode == php_pkg::MODE_V1LINE || mode == php_pkg::MODE_LONG) begin
      if (header_done) begin
        r.status         = php_pkg::ST_OK;
        r.header_version = 2'd1;
        r.consumed_bytes = text_length;
        r.addr_found     = text_has_addr;
      end else begin
        r.status = php_pkg::ST_INCOMPLETE;
      end
    end
    if (r.addr_found) begin
      r.source_address      = collect[0];
      r.destination_address = collect[1];
      r.source_port         = collect[2][15:0];
      r.destination_port    = collect[3][15:0];
    end
    expected_results.push_back(r);
    clear_parser();
  endfunction

  function automatic void report(string field, logic [31:0] want, logic [31:0] got);
    if (mismatches < 10)
      $display("mismatch in %s: expected %0h, actual %0h", field, want, got);
    mismatches++;
  endfunction

  function automatic void compare_result(php_pkg::result_t got);
    php_pkg::result_t want;
    if (expected_results.size() == 0) begin
      if (mismatches < 10) $display("unexpected result transaction: %0h", got);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    if (got.status != want.status) report("status", want.status, got.status);
    if (got.header_version != want.header_version)
      report("header_version", want.header_version, got.header_version);
    if (got.addr_found != want.addr_found)
      report("addr_found", want.addr_found, got.addr_found);
    if (got.source_address != want.source_address)
      report("source_address", want.source_address, got.source_address);
    if (got.destination_address != want.destination_address)
      report("destination_address", want.destination_address, got.destination_address);
    if (got.source_port != want.source_port)
      report("source_port", want.source_port, got.source_port);
    if (got.destination_port != want.destination_port)
      report("destination_port", want.destination_port, got.destination_port);
    if (got.consumed_bytes != want.consumed_bytes)
      report("consumed_bytes", want.consumed_bytes, got.consumed_bytes);
    if (out_tdata[119:118] != 2'b00) report("pad bits", 32'h0, out_tdata[119:118]);
  endfunction

  initial begin
    mismatches    = 0;
    pending       = 0;
    proxy_cmd_reg = 8'h21;
    tcp4_fam_reg  = 8'h11;
    clear_parser();
  end

  // Results are checked before the byte of the same edge is modeled.
  always @(posedge clk) begin
    if (!rst_n) begin
      proxy_cmd_reg = 8'h21;
      tcp4_fam_reg  = 8'h11;
      clear_parser();
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) compare_result(php_pkg::result_t'(out_tdata[117:0]));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == php_pkg::REG_CMD) proxy_cmd_reg = cfg_data;
        else tcp4_fam_reg = cfg_data;
      end
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tlast);
    end
    pending = expected_results.size();
  end

endmodule

@@ tb/proxy_header_parser_core_tb.sv @@
// ----------------------------------------------------------------------------
// PROXY header parser testbench
// Feeds directed and random connection buffers (binary and text headers,
// damaged and truncated ones, and noise) through the parser core under
// several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module proxy_header_parser_core_tb;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // [7:0] data_byte
  logic         in_tlast;   // end_of_buffer
  logic         out_tvalid;
  logic         out_tready;
  // [1:0] status, [3:2] header_version, [4] addr_found, [36:5] source_address,
  // [68:37] destination_address, [84:69] source_port, [100:85] destination_port,
  // [117:101] consumed_bytes, [119:118] zero
  logic [119:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [7:0]   cfg_data;
  int           fail_count;
  int           pending;

  logic [7:0]   buffer_bytes [$];
  logic [7:0]   cur_cmd;
  logic [7:0]   cur_fam;
  int           bytes_sent;
  int           hold_left;
  logic         calm;

  proxy_header_parser_core i_dut (.*);

  proxy_header_parser_core_checker i_checker (.*);

  always #5 clk = ~clk;

  initial begin
    #50000000;
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = calm || ($urandom_range(99) >= 8);
      end
    end
  end

  task automatic send_buffer();
    int n;
    for (int i = 0; i < buffer_bytes.size(); i++) begin
      if (!calm && $urandom_range(99) < 8) begin
        in_tvalid = 1'b0;
        n = $urandom_range(1, 4);
        repeat (n) @(negedge clk);
      end
      in_tvalid = 1'b1;
      in_tdata  = buffer_bytes[i];
      in_tlast  = (i == buffer_bytes.size() - 1);
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      @(negedge clk);
      bytes_sent++;
    end
    buffer_bytes.delete();
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_registers(logic [7:0] cmd, logic [7:0] fam);
    wait_idle();
    write_reg(php_pkg::REG_CMD, cmd);
    write_reg(php_pkg::REG_FAM, fam);
    cur_cmd = cmd;
    cur_fam = fam;
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) buffer_bytes.push_back(s[i]);
  endfunction

  // Binary header with a body of len bytes; keep cuts the buffer short.
  function automatic void add_binary(logic [7:0] cmd, logic [7:0] fam, logic [15:0] len,
                                     logic [7:0] fill, int keep);
    logic [7:0] sig [12];
    sig = '{8'h0D, 8'h0A, 8'h0D, 8'h0A, 8'h00, 8'h0D, 8'h0A, 8'h51, 8'h55, 8'h49,
            8'h54, 8'h0A};
    foreach (sig[i]) buffer_bytes.push_back(sig[i]);
    buffer_bytes.push_back(cmd);
    buffer_bytes.push_back(fam);
    buffer_bytes.push_back(len[15:8]);
    buffer_bytes.push_back(len[7:0]);
    for (int i = 0; i < len; i++)
      buffer_bytes.push_back((fill == 8'h00) ? 8'($urandom) : fill);
    while (keep > 0 && buffer_bytes.size() > keep) void'(buffer_bytes.pop_back());
  endfunction

  function automatic string rand_octet();
    int r;
    r = $urandom_range(99);
    if (r < 4) return $sformatf("%0d", $urandom_range(256, 999));
    if (r < 6) return "0000";
    if (r < 8) return "";
    if (r < 12) return $sformatf("%03d", $urandom_range(255));
    return $sformatf("%0d", $urandom_range(255));
  endfunction

  function automatic string rand_quad();
    string s;
    int n;
    n = ($urandom_range(99) < 5) ? $urandom_range(2, 5) : 4;
    s = rand_octet();
    for (int i = 1; i < n; i++) s = {s, ".", rand_octet()};
    if ($urandom_range(99) < 2) s = {s, "x"};
    return s;
  endfunction

  function automatic string rand_port();
    int r;
    r = $urandom_range(99);
    if (r < 4) return $sformatf("%0d", $urandom_range(65536, 99999));
    if (r < 6) return "123456";
    if (r < 8) return "8a";
    if (r < 14) return "65535";
    return $sformatf("%0d", $urandom_range(65535));
  endfunction

  function automatic string gap();
    return ($urandom_range(99) < 15) ? "   " : " ";
  endfunction

  // Random text header, mostly well formed.
  function automatic void add_random_text();
    string s;
    int r;
    r = $urandom_range(99);
    s = (r < 88) ? "TCP4" : (r < 92) ? "TCP6" : (r < 96) ? "UNKNOWN" : "TCP";
    s = {"PROXY ", s, gap(), rand_quad(), gap(), rand_quad(), gap(), rand_port()};
    if ($urandom_range(99) < 95) s = {s, gap(), rand_port()};
    if ($urandom_range(99) < 8) s = {s, " extra 12"};
    if ($urandom_range(99) < 6) s = {s, "\r?"};
    if ($urandom_range(99) < 6) while (s.len() < 120) s = {s, " "};
    if ($urandom_range(99) < 94) s = {s, "\r\n"};
    add_text(s);
    r = $urandom_range(3);
    repeat (r) buffer_bytes.push_back(8'($urandom));
    if ($urandom_range(99) < 8)
      while (buffer_bytes.size() > 1 && $urandom_range(3) != 0) void'(buffer_bytes.pop_back());
  endfunction

  function automatic void add_random_binary();
    logic [7:0] cmd;
    logic [7:0] fam;
    logic [15:0] len;
    int keep;
    int r;
    r = $urandom_range(99);
    cmd = (r < 80) ? cur_cmd : (r < 88) ? {4'h2, 4'($urandom)} : 8'($urandom);
    fam = ($urandom_range(99) < 85) ? cur_fam : 8'($urandom);
    r = $urandom_range(99);
    len = (r < 50) ? 16'd12 : (r < 95) ? 16'($urandom_range(20)) : 16'($urandom_range(300));
    keep = ($urandom_range(99) < 10) ? $urandom_range(1, 16 + len) : 0;
    add_binary(cmd, fam, len, 8'h00, keep);
    if (keep == 0) repeat ($urandom_range(3)) buffer_bytes.push_back(8'($urandom));
    if ($urandom_range(99) < 4)
      buffer_bytes[$urandom_range(buffer_bytes.size() - 1)] = 8'($urandom);
  endfunction

  function automatic void add_noise();
    int n;
    int r;
    n = $urandom_range(1, 20);
    r = $urandom_range(2);
    buffer_bytes.push_back((r == 0) ? 8'h0D : (r == 1) ? "P" : 8'($urandom));
    repeat (n - 1) buffer_bytes.push_back(8'($urandom));
  endfunction

  task automatic run_random(int count);
    int r;
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 45) add_random_binary();
      else if (r < 90) add_random_text();
      else add_noise();
      send_buffer();
    end
  endtask

  initial begin
    string line;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = php_pkg::REG_CMD;
    cfg_data   = '0;
    hold_left  = 0;
    calm       = 1'b0;
    bytes_sent = 0;
    cur_cmd    = 8'h21;
    cur_fam    = 8'h11;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed buffers under the reset register values.
    buffer_bytes.push_back(8'h00); send_buffer();
    buffer_bytes.push_back(8'hFF); send_buffer();
    add_text("P"); send_buffer();
    add_text("PROXY"); send_buffer();
    add_text("PROXZ TCP4 1.2.3.4 5.6.7.8 1 2\r\n"); send_buffer();
    add_binary(8'h21, 8'h11, 16'd12, 8'h00, 11); send_buffer();
    add_binary(8'h21, 8'h11, 16'd12, 8'hFF, 0); send_buffer();
    add_binary(8'h21, 8'h11, 16'd0, 8'h00, 0); send_buffer();
    add_binary(8'h21, 8'h11, 16'd11, 8'h00, 0); send_buffer();
    add_binary(8'h20, 8'h11, 16'd12, 8'h00, 0); send_buffer();
    add_binary(8'h11, 8'h11, 16'd12, 8'h00, 0); send_buffer();
    add_binary(8'h11, 8'h11, 16'd12, 8'h00, 20); send_buffer();
    add_binary(8'h21, 8'h11, 16'hFFFF, 8'h00, 40); send_buffer();
    add_text("PROXY TCP4 255.255.255.255 255.255.255.255 65535 65535\r\nzz"); send_buffer();
    add_text("PROXY TCP4 0.0.0.0 0.0.0.0 0 0\r\n"); send_buffer();
    add_text("PROXY  TCP4   1.2.3.4 5.6.7.8 80 443 a b c\r\n"); send_buffer();
    add_text("PROXY TCP4 1.2.3.4 5.6\r7.8 80 443\r\n"); send_buffer();
    add_text("PROXY TCP4 256.2.3.4 5.6.7.8 80 65536\r\n"); send_buffer();
    add_text("PROXY TCP4 1.2.3.4 5.6.7.8 80 443"); send_buffer();
    line = "PROXY TCP4 1.2.3.4 5.6.7.8 1 2";
    while (line.len() < 106) line = {line, " "};
    add_text({line, "\r\n"}); send_buffer();
    add_text({line, " \r\n"}); send_buffer();

    // Random phases over several register settings.
    run_random(60);
    set_registers(8'h00, 8'h00);
    run_random(50);
    set_registers(8'hFF, 8'hFF);
    calm = 1'b1;
    run_random(60);
    calm = 1'b0;
    set_registers(8'h22, 8'h12);
    hold_left = 400;
    repeat (60) begin
      add_noise();
      buffer_bytes = buffer_bytes[0:0];
      send_buffer();
    end
    run_random(60);
    set_registers(8'($urandom), 8'($urandom));
    run_random(40);
    set_registers(8'h21, 8'h11);
    run_random(60);

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
